### src/pcrb_pkg.sv
// ----------------------------------------------------------------------------
// pcrb_pkg: shared definitions for the rotating pixel-format blit
// Sizes, register indexes, rotation codes and the structs passed between the
// configuration, scan and index stages.
// ----------------------------------------------------------------------------
package pcrb_pkg;

    localparam int MAX_DIM    = 2048;
    localparam int MAX_LINE   = 4096;

    // Fixed field widths.
    localparam int SIZE_REG_W = 12;
    localparam int LINE_REG_W = 13;
    localparam int IDX_W      = 24;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Widths that follow from the size limits.
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int LINE_W     = $clog2(MAX_LINE + 1);
    localparam int TDATA_W    = ((IDX_W + PIX_W + 7) / 8) * 8;

    localparam logic [SIZE_REG_W-1:0] RESET_WIDTH  = SIZE_REG_W'(640);
    localparam logic [SIZE_REG_W-1:0] RESET_HEIGHT = SIZE_REG_W'(480);
    localparam logic [LINE_REG_W-1:0] RESET_LINE   = LINE_REG_W'(640);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION = 3'd0,
        CFG_FORMAT   = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_LINE     = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    typedef enum logic {
        FMT_RGB565 = 1'b0,
        FMT_ABGR32 = 1'b1
    } t_format;

    // Effective configuration, sizes already clamped.
    typedef struct packed {
        t_rotation         rotation;
        t_format           source_format;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [LINE_W-1:0] line;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
    } t_pos;

    // Stage register contents: index = offset + line_sel * line length.
    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] line_sel;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_stage;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [LINE_W-1:0] clamp_line(input logic [LINE_REG_W-1:0] v);
        logic [LINE_W-1:0] r;
        if (v == '0) begin
            r = LINE_W'(1);
        end else if (32'(v) > 32'(MAX_LINE)) begin
            r = LINE_W'(MAX_LINE);
        end else begin
            r = LINE_W'(v);
        end
        return r;
    endfunction

endpackage

### src/pixel_convert_rotate_blit_top.sv
// ----------------------------------------------------------------------------
// pixel_convert_rotate_blit_top: rotating RGB565/ABGR to ARGB8888 blit
// Top level: configuration port, raster scan stage and index stage.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock in raster order while the
// output is not stalled and returns one result transaction per pixel, also
// at one per clock, via the stage and output registers: the first holds the
// converted pixel and the rotation operands, the second the index from the
// single line-length multiply-add. The stage register can take a new pixel
// while a result waits in the output register. Configuration is accepted in
// every cycle; a width or height write sends the scan back to the first pixel.
module pixel_convert_rotate_blit_top
    import pcrb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Source pixel stream. tdata: [31:0] src_pixel.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,
    // Destination stream. tdata: [23:0] dest_index, [55:24] dest_pixel.
    // tlast: frame_last.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pcrb_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast,
    // Configuration writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcrb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcrb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcrb_pkg::*;

    t_cfg   cfg;
    t_pos   pos;
    t_stage stage;
    logic   restart;
    logic   stage_valid;
    logic   stage_ready;

    pcrb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    pcrb_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_restart     (restart),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_stage_ready (stage_ready),
        .o_stage_valid (stage_valid),
        .o_stage       (stage),
        .o_pos         (pos)
    );

    pcrb_index u_index (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_stage_valid (stage_valid),
        .o_stage_ready (stage_ready),
        .i_stage       (stage),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    // The scan position always lies inside the effective frame.
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(pos.col) < cfg.width)
        else $error("column counter outside the frame");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(pos.row) < cfg.height)
        else $error("row counter outside the frame");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready
         && ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT)))
        |=> (pos.col == '0) && (pos.row == '0))
        else $error("frame size write did not restart the scan");

    a_stage_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && stage_ready) |=> o_m_tvalid)
        else $error("staged pixel was not moved to the output register");

endmodule

### src/pcrb_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcrb_cfg_regs: configuration registers
// Holds the five control registers, presents their clamped effective values
// and flags a frame restart when a frame dimension is written.
// ----------------------------------------------------------------------------
module pcrb_cfg_regs
    import pcrb_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcrb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcrb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pcrb_pkg::t_cfg                    o_cfg,
    output logic                              o_restart
);
    import pcrb_pkg::*;

    t_rotation               r_rotation;
    t_format                 r_format;
    logic [SIZE_REG_W-1:0]   r_width;
    logic [SIZE_REG_W-1:0]   r_height;
    logic [LINE_REG_W-1:0]   r_line;
    logic                    wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROT_0;
            r_format   <= FMT_RGB565;
            r_width    <= RESET_WIDTH;
            r_height   <= RESET_HEIGHT;
            r_line     <= RESET_LINE;
        end else if (wr) begin
            case (i_cfg_index)
                CFG_ROTATION: r_rotation <= t_rotation'(i_cfg_data[1:0]);
                CFG_FORMAT:   r_format   <= t_format'(i_cfg_data[0]);
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_LINE:     r_line     <= i_cfg_data[LINE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Writing either dimension starts a new frame at the top left pixel.
    assign o_restart = wr && ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));

    always_comb begin
        o_cfg.rotation      = r_rotation;
        o_cfg.source_format = r_format;
        o_cfg.width         = clamp_dim(r_width);
        o_cfg.height        = clamp_dim(r_height);
        o_cfg.line          = clamp_line(r_line);
    end

endmodule

### src/pcrb_scan.sv
// ----------------------------------------------------------------------------
// pcrb_scan: raster counters and first pipeline stage
// Tracks the column and row of the next source pixel, converts the pixel
// format and selects the index operands for the active rotation.
// ----------------------------------------------------------------------------
module pcrb_scan
    import pcrb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcrb_pkg::t_cfg                i_cfg,
    input  logic                          i_restart,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pcrb_pkg::PIX_W-1:0]    i_s_tdata,
    input  logic                          i_stage_ready,
    output logic                          o_stage_valid,
    output pcrb_pkg::t_stage              o_stage,
    output pcrb_pkg::t_pos                o_pos
);
    import pcrb_pkg::*;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             r_valid;
    t_stage           r_stage;
    t_stage           n_stage;
    logic             accept;
    logic [DIM_W-1:0] w_m1;
    logic [DIM_W-1:0] h_m1;
    logic [CNT_W-1:0] col_rev;
    logic [CNT_W-1:0] row_rev;
    logic             col_end;
    logic             row_end;

    assign o_s_tready = !r_valid || i_stage_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        w_m1    = i_cfg.width - DIM_W'(1);
        h_m1    = i_cfg.height - DIM_W'(1);
        col_rev = CNT_W'(w_m1 - DIM_W'(r_col));
        row_rev = CNT_W'(h_m1 - DIM_W'(r_row));
        col_end = (DIM_W'(r_col) == w_m1);
        row_end = (DIM_W'(r_row) == h_m1);

        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end

        case (i_cfg.rotation)
            ROT_0: begin
                n_stage.offset   = r_col;
                n_stage.line_sel = r_row;
            end
            ROT_90: begin
                n_stage.offset   = row_rev;
                n_stage.line_sel = r_col;
            end
            ROT_180: begin
                n_stage.offset   = col_rev;
                n_stage.line_sel = row_rev;
            end
            default: begin
                n_stage.offset   = r_row;
                n_stage.line_sel = col_rev;
            end
        endcase

        // RGB565 channels go to the top of each byte; ABGR swaps red and blue.
        if (i_cfg.source_format == FMT_ABGR32) begin
            n_stage.pixel = {ALPHA_OPAQUE, i_s_tdata[7:0], i_s_tdata[15:8],
                             i_s_tdata[23:16]};
        end else begin
            n_stage.pixel = {ALPHA_OPAQUE, i_s_tdata[15:11], 3'b000,
                             i_s_tdata[10:5], 2'b00, i_s_tdata[4:0], 3'b000};
        end
        n_stage.last = col_end && row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_stage_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_stage       = r_stage;
    assign o_pos.col     = r_col;
    assign o_pos.row     = r_row;

endmodule

### src/pcrb_index.sv
// ----------------------------------------------------------------------------
// pcrb_index: destination index and output register
// Forms offset plus line select times the line length and holds the result
// transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module pcrb_index
    import pcrb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcrb_pkg::t_cfg                i_cfg,
    input  logic                          i_stage_valid,
    output logic                          o_stage_ready,
    input  pcrb_pkg::t_stage              i_stage,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pcrb_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast
);
    import pcrb_pkg::*;

    localparam int PROD_W = CNT_W + LINE_W;

    logic              r_valid;
    logic [IDX_W-1:0]  r_index;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_last;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  n_index;
    logic              load;

    assign o_stage_ready = !r_valid || i_m_tready;
    assign load          = i_stage_valid && o_stage_ready;

    // The index wraps at the index width.
    always_comb begin
        prod    = PROD_W'(i_stage.line_sel) * PROD_W'(i_cfg.line);
        n_index = IDX_W'(prod + PROD_W'(i_stage.offset));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_index <= n_index;
            r_pixel <= i_stage.pixel;
            r_last  <= i_stage.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = TDATA_W'({r_pixel, r_index});
    assign o_m_tlast  = r_last;

endmodule
